/* rtl/core/mlqs_pkg.sv */
package mlqs_pkg;

    // geometry
    localparam int NUM_LEVELS        = 3;
    localparam int LEVEL_DEPTH_DEF   = 16;

    // configuration register indexes
    localparam logic [2:0] REG_QUANTUM0  = 3'd0;
    localparam logic [2:0] REG_QUANTUM1  = 3'd1;
    localparam logic [2:0] REG_QUANTUM2  = 3'd2;
    localparam logic [2:0] REG_HIGH_THR  = 3'd3;
    localparam logic [2:0] REG_MID_THR   = 3'd4;

    // configuration reset values
    localparam logic [7:0] QUANTUM0_RST  = 8'd3;
    localparam logic [7:0] QUANTUM1_RST  = 8'd2;
    localparam logic [7:0] QUANTUM2_RST  = 8'd1;
    localparam logic [7:0] HIGH_THR_RST  = 8'd100;
    localparam logic [7:0] MID_THR_RST   = 8'd50;

    // command opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_STEP   = 1'b1;

    // level codes
    localparam logic [1:0] LVL_TOP = 2'd0;
    localparam logic [1:0] LVL_MID = 2'd1;
    localparam logic [1:0] LVL_BOT = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [15:0] job_id;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [7:0]  priority_req;
    } t_cmd;

    typedef struct packed {
        logic        accepted;
        logic        completed;
        logic [15:0] done_id;
        logic [15:0] done_arrival;
        logic [15:0] done_burst;
        logic [31:0] completion_time;
        logic [31:0] waiting_time;
        logic        idle_tick;
        logic        all_empty;
        logic [1:0]  served_level;
    } t_result;

    // job entry: original burst, remaining time, arrival, id
    typedef struct packed {
        logic [15:0] orig;
        logic [15:0] rem;
        logic [15:0] arr;
        logic [15:0] id;
    } t_entry;

endpackage

/* rtl/core/multilevel_queue_scheduler_unit.sv */
// three-level queue scheduler with round robin inside each level. a beat on start
// (taken while busy is low) either files a job into a level chosen by its priority
// against the two thresholds, or runs one scheduling step on the head of the highest
// non-empty level. every command gives exactly one result beat on o_result, marked by
// o_done for a single cycle; the receiver cannot stall, so o_done must be sampled
// when it is high. a result beat appears in the same cycle that busy falls, and a new
// command may be issued in that same cycle. an insert, or a step that finds all levels
// empty, passes through decode only; a step whose head has not arrived goes on to run;
// a step that runs a job goes on to run and finish, as set by the registered read of
// the job store and the one shared 33-bit adder, which first advances the scheduler
// clock and then forms the waiting time. the user must write configuration through the
// apb port only while no command is in flight; the block itself does not enforce it.
module multilevel_queue_scheduler_unit #(
    parameter int LEVEL_DEPTH = mlqs_pkg::LEVEL_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  mlqs_pkg::t_cmd    i_cmd,
    // result channel
    output logic              o_done,
    output mlqs_pkg::t_result o_result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import mlqs_pkg::*;

    localparam int NUM_ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
    localparam int IDX_W       = $clog2(LEVEL_DEPTH);
    localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W      = $clog2(NUM_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_FINISH
    } t_state;

    // control and status
    t_state            r_state;
    t_cmd              r_cmd;
    logic [1:0]        r_lvl;
    logic [IDX_W-1:0]  r_head  [NUM_LEVELS];
    logic [IDX_W-1:0]  r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]  r_count [NUM_LEVELS];
    logic [31:0]       r_clock;
    logic [15:0]       r_rem;
    logic              r_done;
    t_result           r_result;

    // configuration registers
    logic [7:0]        r_quantum0;
    logic [7:0]        r_quantum1;
    logic [7:0]        r_quantum2;
    logic [7:0]        r_high_thr;
    logic [7:0]        r_mid_thr;

    // job store
    t_entry            r_mem [NUM_ENTRIES];
    t_entry            r_rd_data;

    logic              cmd_accept;
    logic              cfg_write;
    logic [2:0]        cfg_index;

    logic [1:0]        ins_lvl;
    logic [1:0]        step_lvl;
    logic              all_empty;
    logic [1:0]        cur_lvl;
    logic [IDX_W-1:0]  cur_head;
    logic [IDX_W-1:0]  cur_tail;
    logic [CNT_W-1:0]  cur_count;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_inc;
    logic              lvl_full;
    logic [7:0]        cur_quantum;
    logic [15:0]       run_len;
    logic              not_arrived;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              mem_we;
    t_entry            mem_wdata;

    // shared adder
    logic [32:0]       alu_a;
    logic [32:0]       alu_b;
    logic              alu_sub;
    logic [32:0]       alu_raw;
    logic [31:0]       alu_res;
    logic [16:0]       arr_plus_burst;

    assign cmd_accept = start && !busy;
    assign busy       = (r_state != ST_IDLE);
    assign o_done     = r_done;
    assign o_result   = r_result;

    // apb: always ready, write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_comb begin
        unique case (cfg_index)
            REG_QUANTUM0: prdata = {24'd0, r_quantum0};
            REG_QUANTUM1: prdata = {24'd0, r_quantum1};
            REG_QUANTUM2: prdata = {24'd0, r_quantum2};
            REG_HIGH_THR: prdata = {24'd0, r_high_thr};
            REG_MID_THR:  prdata = {24'd0, r_mid_thr};
            default:      prdata = 32'd0;
        endcase
    end

    // level that an insert files into: high threshold wins
    always_comb begin
        priority if (r_cmd.priority_req > r_high_thr) begin
            ins_lvl = LVL_TOP;
        end else if (r_cmd.priority_req > r_mid_thr) begin
            ins_lvl = LVL_MID;
        end else begin
            ins_lvl = LVL_BOT;
        end
    end

    // highest non-empty level for a step
    always_comb begin
        all_empty = 1'b0;
        priority if (r_count[LVL_TOP] != '0) begin
            step_lvl = LVL_TOP;
        end else if (r_count[LVL_MID] != '0) begin
            step_lvl = LVL_MID;
        end else begin
            step_lvl  = LVL_BOT;
            all_empty = (r_count[LVL_BOT] == '0);
        end
    end

    // one level pointer set is looked at per cycle
    always_comb begin
        if (r_state == ST_DECODE) begin
            cur_lvl = (r_cmd.opcode == OP_INSERT) ? ins_lvl : step_lvl;
        end else begin
            cur_lvl = r_lvl;
        end
    end

    assign cur_head  = r_head[cur_lvl];
    assign cur_tail  = r_tail[cur_lvl];
    assign cur_count = r_count[cur_lvl];
    assign lvl_full  = (cur_count == CNT_W'(LEVEL_DEPTH));
    assign head_inc  = (cur_head == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    assign tail_inc  = (cur_tail == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : cur_tail + 1'b1;

    always_comb begin
        unique case (cur_lvl)
            LVL_TOP: cur_quantum = r_quantum0;
            LVL_MID: cur_quantum = r_quantum1;
            default: cur_quantum = r_quantum2;
        endcase
    end

    // slice is the smaller of remaining time and quantum
    assign run_len     = (r_rd_data.rem < {8'd0, cur_quantum}) ? r_rd_data.rem
                                                               : {8'd0, cur_quantum};
    assign not_arrived = ({16'd0, r_rd_data.arr} > r_clock);

    assign rd_addr = ADDR_W'(cur_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(cur_head);
    assign wr_addr = ADDR_W'(cur_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(cur_tail);

    // store writes: new job on insert, requeue of an unfinished job
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rd_data;
        if (r_state == ST_DECODE && r_cmd.opcode == OP_INSERT && !lvl_full) begin
            mem_we         = 1'b1;
            mem_wdata.id   = r_cmd.job_id;
            mem_wdata.arr  = r_cmd.arrival_time;
            mem_wdata.rem  = r_cmd.burst_time;
            mem_wdata.orig = r_cmd.burst_time;
        end else if (r_state == ST_FINISH && r_rem != 16'd0) begin
            mem_we        = 1'b1;
            mem_wdata.rem = r_rem;
        end
    end

    // shared adder: clock advance in run, waiting time in finish
    assign arr_plus_burst = {1'b0, r_rd_data.arr} + {1'b0, r_rd_data.orig};

    always_comb begin
        alu_a   = {1'b0, r_clock};
        alu_sub = 1'b0;
        alu_b   = 33'd0;
        unique case (r_state)
            ST_RUN: begin
                alu_b = not_arrived ? 33'd1 : {17'd0, run_len};
            end
            ST_FINISH: begin
                alu_sub = 1'b1;
                alu_b   = {16'd0, arr_plus_burst};
            end
            default: begin
                alu_b = 33'd0;
            end
        endcase
    end

    assign alu_raw = alu_a + (alu_sub ? ~alu_b : alu_b) + {32'd0, alu_sub};
    // carry on add saturates high, borrow on subtract clamps to zero
    assign alu_res = alu_raw[32] ? (alu_sub ? 32'd0 : 32'hFFFF_FFFF) : alu_raw[31:0];

    // job store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= mem_wdata;
        end
        if (r_state == ST_DECODE) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_done     <= 1'b0;
            r_clock    <= 32'd0;
            r_quantum0 <= QUANTUM0_RST;
            r_quantum1 <= QUANTUM1_RST;
            r_quantum2 <= QUANTUM2_RST;
            r_high_thr <= HIGH_THR_RST;
            r_mid_thr  <= MID_THR_RST;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_done <= 1'b0;

            if (cfg_write) begin
                unique case (cfg_index)
                    REG_QUANTUM0: r_quantum0 <= pwdata[7:0];
                    REG_QUANTUM1: r_quantum1 <= pwdata[7:0];
                    REG_QUANTUM2: r_quantum2 <= pwdata[7:0];
                    REG_HIGH_THR: r_high_thr <= pwdata[7:0];
                    REG_MID_THR:  r_mid_thr  <= pwdata[7:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (cmd_accept) begin
                        // result fields start cleared for every command
                        r_result <= '0;
                        r_cmd    <= i_cmd;
                        r_state  <= ST_DECODE;
                    end
                end

                ST_DECODE: begin
                    r_lvl <= cur_lvl;
                    if (r_cmd.opcode == OP_INSERT) begin
                        // full level rejects and leaves state alone
                        if (!lvl_full) begin
                            r_tail[cur_lvl]  <= tail_inc;
                            r_count[cur_lvl] <= cur_count + 1'b1;
                        end
                        r_result.accepted <= !lvl_full;
                        r_done            <= 1'b1;
                        r_state           <= ST_IDLE;
                    end else if (all_empty) begin
                        r_result.all_empty <= 1'b1;
                        r_done             <= 1'b1;
                        r_state            <= ST_IDLE;
                    end else begin
                        // head entry is read at this edge
                        r_state <= ST_RUN;
                    end
                end

                ST_RUN: begin
                    r_clock <= alu_res;
                    if (not_arrived) begin
                        r_result.idle_tick    <= 1'b1;
                        r_result.served_level <= r_lvl;
                        r_done                <= 1'b1;
                        r_state               <= ST_IDLE;
                    end else begin
                        r_rem   <= r_rd_data.rem - run_len;
                        r_state <= ST_FINISH;
                    end
                end

                ST_FINISH: begin
                    r_result.served_level <= r_lvl;
                    r_head[r_lvl]         <= head_inc;
                    if (r_rem == 16'd0) begin
                        r_count[r_lvl]           <= cur_count - 1'b1;
                        r_result.completed       <= 1'b1;
                        r_result.done_id         <= r_rd_data.id;
                        r_result.done_arrival    <= r_rd_data.arr;
                        r_result.done_burst      <= r_rd_data.orig;
                        r_result.completion_time <= r_clock;
                        r_result.waiting_time    <= alu_res;
                    end else begin
                        // unfinished job goes to the tail with its new remaining time
                        r_tail[r_lvl] <= tail_inc;
                    end
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* test/tb_multilevel_queue_scheduler_unit.sv */
`timescale 1ns / 1ps

module tb_multilevel_queue_scheduler_unit;
    import mlqs_pkg::*;

    localparam int QDEPTH        = LEVEL_DEPTH_DEF;
    localparam int NUM_CFG_REGS  = REG_MID_THR + 1;
    localparam int NUM_REG_SLOTS = 8;          // 5-bit byte address, one word per slot
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 225;
    localparam int CYCLE_LIMIT   = 250000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_cmd        i_cmd   = '0;
    logic        o_done;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    multilevel_queue_scheduler_unit DUT (
        .i_clk    (i_clk),    .i_rst_n  (i_rst_n),
        .start    (start),    .busy     (busy),     .i_cmd   (i_cmd),
        .o_done   (o_done),   .o_result (o_result),
        .psel     (psel),     .penable  (penable),  .pwrite  (pwrite),
        .paddr    (paddr),    .pwdata   (pwdata),   .prdata  (prdata),
        .pready   (pready)
    );

    // 2 ns clock; reset is held low at the start and then released
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // scheduler model: configuration, per-level ring queues, clock
    // ---------------------------------------------------------------
    logic [7:0]  quantum [NUM_LEVELS] = '{QUANTUM0_RST, QUANTUM1_RST, QUANTUM2_RST};
    logic [7:0]  high_thr = HIGH_THR_RST;
    logic [7:0]  mid_thr  = MID_THR_RST;
    t_entry      job_slots [NUM_LEVELS][QDEPTH];
    int unsigned lvl_head  [NUM_LEVELS] = '{default: 0};
    int unsigned lvl_tail  [NUM_LEVELS] = '{default: 0};
    int unsigned lvl_count [NUM_LEVELS] = '{default: 0};
    logic [31:0] sched_clk = '0;

    // results owed by the block, oldest first
    t_result pending_results [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int n_insert    = 0;
    int n_refused   = 0;
    int n_step      = 0;
    int n_completed = 0;
    int n_idle      = 0;
    int n_empty     = 0;
    int n_settings  = 0;

    // saturating clock advance, the clock never wraps
    function automatic logic [31:0] clock_advance(logic [31:0] now, logic [15:0] amount);
        logic [32:0] sum;
        sum = {1'b0, now} + 33'(amount);
        return sum[32] ? '1 : sum[31:0];
    endfunction

    // one command applied to the model, returns the beat the block must produce
    function automatic t_result next_sched_result(t_cmd c);
        t_result     r;
        logic [1:0]  lvl;
        t_entry      e;
        logic [15:0] run;
        logic [32:0] owed;
        r = '0;
        if (c.opcode == OP_INSERT) begin
            // high threshold wins, so a mid above high leaves the middle level unreachable
            if (c.priority_req > high_thr) lvl = LVL_TOP;
            else if (c.priority_req > mid_thr) lvl = LVL_MID;
            else lvl = LVL_BOT;
            if (lvl_count[lvl] < QDEPTH) begin
                job_slots[lvl][lvl_tail[lvl]] = '{orig: c.burst_time, rem: c.burst_time,
                                                  arr: c.arrival_time, id: c.job_id};
                lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QDEPTH;
                lvl_count[lvl]++;
                r.accepted = 1'b1;
            end
            return r;
        end
        if (lvl_count[LVL_TOP] != 0) lvl = LVL_TOP;
        else if (lvl_count[LVL_MID] != 0) lvl = LVL_MID;
        else if (lvl_count[LVL_BOT] != 0) lvl = LVL_BOT;
        else begin
            r.all_empty = 1'b1;
            return r;
        end
        r.served_level = lvl;
        e = job_slots[lvl][lvl_head[lvl]];
        // head not arrived yet: one idle tick, no rotation
        if (e.arr > sched_clk) begin
            sched_clk = clock_advance(sched_clk, 16'd1);
            r.idle_tick = 1'b1;
            return r;
        end
        run = (e.rem < quantum[lvl]) ? e.rem : 16'(quantum[lvl]);
        sched_clk = clock_advance(sched_clk, run);
        e.rem = e.rem - run;
        lvl_head[lvl] = (lvl_head[lvl] + 1) % QDEPTH;
        if (e.rem == 0) begin
            owed = 33'(e.orig) + 33'(e.arr);
            r.completed       = 1'b1;
            r.done_id         = e.id;
            r.done_arrival    = e.arr;
            r.done_burst      = e.orig;
            r.completion_time = sched_clk;
            // only a saturated clock can end up short of arrival plus burst
            r.waiting_time    = ({1'b0, sched_clk} >= owed) ? sched_clk - owed[31:0] : '0;
            lvl_count[lvl]--;
        end else begin
            // unfinished job goes round to the tail of its level
            job_slots[lvl][lvl_tail[lvl]] = e;
            lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QDEPTH;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h",
                 what, cycle_count, got, want);
        mismatches++;
    endtask

    task automatic check_result(t_result got, t_result want);
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
        if (got.completed !== want.completed)
            report_mismatch("completed", 64'(got.completed), 64'(want.completed));
        if (got.done_id !== want.done_id)
            report_mismatch("done_id", 64'(got.done_id), 64'(want.done_id));
        if (got.done_arrival !== want.done_arrival)
            report_mismatch("done_arrival", 64'(got.done_arrival),
                            64'(want.done_arrival));
        if (got.done_burst !== want.done_burst)
            report_mismatch("done_burst", 64'(got.done_burst), 64'(want.done_burst));
        if (got.completion_time !== want.completion_time)
            report_mismatch("completion_time", 64'(got.completion_time),
                            64'(want.completion_time));
        if (got.waiting_time !== want.waiting_time)
            report_mismatch("waiting_time", 64'(got.waiting_time),
                            64'(want.waiting_time));
        if (got.idle_tick !== want.idle_tick)
            report_mismatch("idle_tick", 64'(got.idle_tick), 64'(want.idle_tick));
        if (got.all_empty !== want.all_empty)
            report_mismatch("all_empty", 64'(got.all_empty), 64'(want.all_empty));
        if (got.served_level !== want.served_level)
            report_mismatch("served_level", 64'(got.served_level),
                            64'(want.served_level));
    endtask

    // result beats cannot be held off, so every strobe is taken at its edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing pending", 64'd1, 64'd0);
            else
                check_result(o_result, pending_results.pop_front());
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // command side
    // ---------------------------------------------------------------
    function automatic t_cmd mk_cmd(logic op, logic [15:0] id, logic [15:0] arr,
                                    logic [15:0] burst, logic [7:0] prio);
        t_cmd c;
        c.opcode       = op;
        c.job_id       = id;
        c.arrival_time = arr;
        c.burst_time   = burst;
        c.priority_req = prio;
        return c;
    endfunction

    function automatic t_result mk_res(bit acc, bit comp, logic [15:0] id, logic [15:0] arr,
                                       logic [15:0] burst, logic [31:0] ct, logic [31:0] wt,
                                       bit idle, bit empty, logic [1:0] lvl);
        t_result r;
        r.accepted        = acc;
        r.completed       = comp;
        r.done_id         = id;
        r.done_arrival    = arr;
        r.done_burst      = burst;
        r.completion_time = ct;
        r.waiting_time    = wt;
        r.idle_tick       = idle;
        r.all_empty       = empty;
        r.served_level    = lvl;
        return r;
    endfunction

    // well-formed jobs arrive close to the current clock so levels keep moving;
    // noisy phases also throw in far-future arrivals and huge bursts
    function automatic t_cmd random_cmd(bit insert_heavy, bit noisy);
        t_cmd        c;
        logic [16:0] soon;
        int          pick;
        c.opcode = ($urandom_range(99) < (insert_heavy ? 60 : 25)) ? OP_INSERT : OP_STEP;
        c.job_id = 16'($urandom);
        if ($urandom_range(9) < 4) begin
            pick = int'($urandom_range(1) ? high_thr : mid_thr) + int'($urandom_range(2)) - 1;
            c.priority_req = (pick < 0) ? 8'd0 : (pick > 255) ? 8'hFF : 8'(pick);
        end else begin
            c.priority_req = 8'($urandom);
        end
        if (c.opcode == OP_STEP || (noisy && $urandom_range(9) == 0)) begin
            // step payload is don't-care, so it carries random bits too
            c.arrival_time = 16'($urandom);
            c.burst_time   = 16'($urandom);
            return c;
        end
        soon = {1'b0, sched_clk[15:0]} + 17'($urandom_range(6));
        if (sched_clk > 32'hFFFF) c.arrival_time = 16'($urandom);
        else c.arrival_time = soon[16] ? 16'hFFFF : soon[15:0];
        c.burst_time = ($urandom_range(9) < 8) ? 16'($urandom_range(12))
                                                : 16'($urandom_range(300));
        return c;
    endfunction

    // drive one command beat and hold it until the block takes it
    task automatic send_cmd(t_cmd c, bit typed, t_result want);
        t_result pred;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        pred = next_sched_result(c);
        pending_results.push_back(typed ? want : pred);
        if (c.opcode == OP_INSERT) begin
            n_insert++;
            if (!pred.accepted) n_refused++;
        end else begin
            n_step++;
            if (pred.completed) n_completed++;
            if (pred.idle_tick) n_idle++;
            if (pred.all_empty) n_empty++;
        end
    endtask

    // hold off until every owed beat is in, plus the longest command latency
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------
    task automatic apb_access(logic wr, logic [2:0] idx, logic [31:0] data,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
    endtask

    task automatic set_register(logic [2:0] idx, logic [7:0] val);
        logic [31:0] rd;
        // upper data bits are junk, only the low byte is kept
        apb_access(1'b1, idx, {24'($urandom), val}, rd);
        case (idx)
            REG_QUANTUM0: quantum[LVL_TOP] = val;
            REG_QUANTUM1: quantum[LVL_MID] = val;
            REG_QUANTUM2: quantum[LVL_BOT] = val;
            REG_HIGH_THR: high_thr = val;
            REG_MID_THR:  mid_thr = val;
            default: ;
        endcase
    endtask

    // read every register back, then release the bus
    task automatic check_config();
        logic [31:0] rd;
        logic [7:0]  want;
        for (int r = 0; r < NUM_CFG_REGS; r++) begin
            apb_access(1'b0, 3'(r), '0, rd);
            case (3'(r))
                REG_QUANTUM0: want = quantum[LVL_TOP];
                REG_QUANTUM1: want = quantum[LVL_MID];
                REG_QUANTUM2: want = quantum[LVL_BOT];
                REG_HIGH_THR: want = high_thr;
                default:      want = mid_thr;
            endcase
            if (rd[7:0] !== want) report_mismatch("register read", 64'(rd), 64'(want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result want;
    } t_dir_row;

    t_dir_row dir_rows [$];

    task automatic add_row(t_cmd c, bit typed, t_result want);
        t_dir_row row;
        row.cmd   = c;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // per-phase settings: quantum 0/1/2, high threshold, mid threshold
    logic [7:0] phase_cfg [RAND_PHASES][NUM_CFG_REGS] = '{
        '{8'd8,   8'd4,   8'd2,   8'd170, 8'd85},
        '{8'd1,   8'd1,   8'd1,   8'd0,   8'd0},     // low extremes
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255},   // high extremes, all to bottom
        '{8'd0,   8'd5,   8'd2,   8'd200, 8'd30},    // top level makes no progress
        '{8'd6,   8'd3,   8'd1,   8'd60,  8'd180},   // mid above high
        '{8'd4,   8'd2,   8'd1,   8'd100, 8'd50}     // replaced by random values
    };

    initial begin : stimulus
        int         idle_pct;
        bit         heavy;
        logic [7:0] v;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // registers come up at their reset values
        check_config();

        // directed table, reset settings
        add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 1,                  // nothing queued
                mk_res(0, 0, 0, 0, 0, 0, 0, 0, 1, LVL_TOP));
        add_row(mk_cmd(OP_INSERT, 16'hFFFF, 0, 0, 8'hFF), 1,     // zero burst, top
                mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0, LVL_TOP));
        add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 1,                  // completes at once
                mk_res(0, 1, 16'hFFFF, 0, 0, 0, 0, 0, 0, LVL_TOP));
        add_row(mk_cmd(OP_INSERT, 0, 0, 16'hFFFF, 0), 1,         // longest burst, bottom
                mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0, LVL_TOP));
        add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 1,                  // one slice, rotates
                mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, LVL_BOT));
        add_row(mk_cmd(OP_INSERT, 7, 4, 2, 101), 1,              // just above high
                mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0, LVL_TOP));
        add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 1,                  // head not arrived
                mk_res(0, 0, 0, 0, 0, 0, 0, 1, 0, LVL_TOP));
        add_row(mk_cmd(OP_INSERT, 8, 0, 5, 100), 1,              // equal to high: middle
                mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0, LVL_TOP));
        add_row(mk_cmd(OP_INSERT, 9, 0, 3, 51), 0, '0);
        add_row(mk_cmd(OP_INSERT, 10, 1, 1, 50), 0, '0);         // equal to mid: bottom
        add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 0, '0);
        add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 0, '0);
        add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 1,                  // arrives, runs 2, done
                mk_res(0, 1, 7, 4, 2, 6, 0, 0, 0, LVL_TOP));
        for (int k = 0; k < 7; k++) add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 0, '0);
        add_row(mk_cmd(OP_INSERT, 16'h5AA5, 16'h0003, 0, 75), 0, '0);
        add_row(mk_cmd(OP_STEP, 0, 0, 0, 0), 0, '0);
        foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

        // random phases, each under its own settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            for (int r = 0; r < NUM_CFG_REGS; r++) begin
                v = (ph == RAND_PHASES - 1) ? 8'($urandom) : phase_cfg[ph][r];
                set_register(3'(r), v);
            end
            // unmapped slots must not disturb anything
            if (ph == 2)
                for (int r = NUM_CFG_REGS; r < NUM_REG_SLOTS; r++)
                    set_register(3'(r), 8'($urandom));
            check_config();
            n_settings++;

            // sender gaps: 24% for two phases, 51% for two, then none
            idle_pct = (ph < 2) ? 24 : (ph < 4) ? 51 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // alternate filling and draining stretches so levels reach full
                heavy = ((n / 30) % 2) == 0;
                send_cmd(random_cmd(heavy, ph == RAND_PHASES - 1), 1'b0, '0);
                if (n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end else if ($urandom_range(99) < idle_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(4, 1)) @(posedge i_clk);
                end
            end
        end

        wait_drained();
        $display("ran %0d commands: %0d inserts (%0d refused by a full level), %0d steps",
                 n_insert + n_step, n_insert, n_refused, n_step);
        $display("steps gave %0d completions, %0d idle ticks, %0d empty; %0d settings used",
                 n_completed, n_idle, n_empty, n_settings + 1);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
